// ===== src/mhpq_pkg.sv =====
package mhpq_pkg;

    typedef enum logic [3:0] {
        OP_INSERT   = 4'd0,
        OP_PEEK     = 4'd1,
        OP_DELETE   = 4'd2,
        OP_INCREASE = 4'd3,
        OP_DECREASE = 4'd4,
        OP_SORT     = 4'd5,
        OP_CLEAR    = 4'd6,
        OP_APPEND   = 4'd7,
        OP_BUILD    = 4'd8
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_BADPOS = 3'd3,
        ST_DIR    = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_OPRD,
        S_OPCHK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DN_WR,
        S_DEL_RDLAST,
        S_DEL_WRROOT,
        S_SORT_RDROOT,
        S_SORT_RDLAST,
        S_SORT_SWAP,
        S_BUILD_NEXT,
        S_BUILD_LOAD,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_EMIT_OUT,
        S_RESULT
    } state_t;

    function automatic logic key_less(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
        return a < b;
    endfunction

endpackage

// ===== src/max_heap_priority_queue_top.sv =====
// Binary max-heap priority queue on one 1R1W synchronous memory (registered read).
// Delete and decrease sift down with two reads and two writes per level.
// Heapsort: N deletes, N emitted beats, then a bottom-up rebuild. One item at a time; the
// next is accepted once its last beat is taken. Reset (aresetn low, synchronous) clears count.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_opcode,
    input  logic signed [31:0]  s_key_value,
    input  logic [6:0]          s_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic signed [31:0]  m_result_key,
    output logic [6:0]          m_entry_total,
    output logic                m_last_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // heap memory, 0-based address = position - 1
    logic signed [31:0] mem [CAPACITY];
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    mhpq_pkg::state_t   state_reg, state_next;
    logic [3:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic [6:0]         pos_reg, pos_next;       // current sift position (1-based)
    logic [6:0]         count_reg, count_next;
    logic [6:0]         total_reg, total_next;   // saved count during sort
    logic signed [31:0] cur_reg, cur_next;       // key moving along the sift
    logic signed [31:0] lkey_reg, lkey_next;     // larger child so far
    logic [6:0]         big_reg, big_next;
    logic [6:0]         bld_reg, bld_next;       // build index
    logic [6:0]         emit_reg, emit_next;
    logic [2:0]         st_reg, st_next;
    logic signed [31:0] res_reg, res_next;
    logic               last_reg, last_next;
    logic               mv_reg, mv_next;
    logic               sorting_reg, sorting_next;

    // 1-based position to memory address
    function automatic logic [AW-1:0] adr(input logic [6:0] p);
        logic [6:0] q;
        q = p - 7'd1;
        return q[AW-1:0];
    endfunction

    localparam logic [6:0] CAP7 = 7'(CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mhpq_pkg::S_IDLE;
            count_reg   <= '0;
            mv_reg      <= 1'b0;
            sorting_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mv_reg      <= mv_next;
            sorting_reg <= sorting_next;
        end
        op_reg    <= op_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        total_reg <= total_next;
        cur_reg   <= cur_next;
        lkey_reg  <= lkey_next;
        big_reg   <= big_next;
        bld_reg   <= bld_next;
        emit_reg  <= emit_next;
        st_reg    <= st_next;
        res_reg   <= res_next;
        last_reg  <= last_next;
    end

    logic [6:0] lpos, rpos;
    assign lpos = {pos_reg[5:0], 1'b0};
    assign rpos = {pos_reg[5:0], 1'b1};

    // state machine: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        cur_next     = cur_reg;
        lkey_next    = lkey_reg;
        big_next     = big_reg;
        bld_next     = bld_reg;
        emit_next    = emit_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        last_next    = last_reg;
        mv_next      = mv_reg;
        sorting_next = sorting_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = cur_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            mhpq_pkg::S_IDLE: begin
                if (s_valid && !mv_reg) begin
                    op_next    = s_opcode;
                    key_next   = s_key_value;
                    pos_next   = s_position;
                    st_next    = mhpq_pkg::ST_OK;
                    res_next   = '0;
                    last_next  = 1'b1;
                    state_next = mhpq_pkg::S_DISPATCH;
                end
            end
            mhpq_pkg::S_DISPATCH: begin
                state_next = mhpq_pkg::S_RESULT;
                unique case (op_reg)
                    mhpq_pkg::OP_INSERT, mhpq_pkg::OP_APPEND: begin
                        if (count_reg >= CAP7) begin
                            st_next = mhpq_pkg::ST_FULL;
                        end else begin
                            // write at the new tail; insert then sifts up holding the key
                            count_next = count_reg + 7'd1;
                            wr_en      = 1'b1;
                            wr_addr    = adr(count_reg + 7'd1);
                            wr_data    = key_reg;
                            cur_next   = key_reg;
                            pos_next   = count_reg + 7'd1;
                            if (op_reg == mhpq_pkg::OP_INSERT) begin
                                state_next = mhpq_pkg::S_UP_RD;
                            end
                        end
                    end
                    mhpq_pkg::OP_PEEK, mhpq_pkg::OP_DELETE, mhpq_pkg::OP_SORT: begin
                        if (count_reg == 7'd0) begin
                            st_next = mhpq_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = adr(7'd1);
                            if (op_reg == mhpq_pkg::OP_SORT) begin
                                total_next   = count_reg;
                                sorting_next = 1'b1;
                                state_next   = mhpq_pkg::S_SORT_RDROOT;
                            end else begin
                                state_next = mhpq_pkg::S_OPRD;
                            end
                        end
                    end
                    mhpq_pkg::OP_INCREASE, mhpq_pkg::OP_DECREASE: begin
                        if (pos_reg == 7'd0 || pos_reg > count_reg) begin
                            st_next = mhpq_pkg::ST_BADPOS;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = adr(pos_reg);
                            state_next = mhpq_pkg::S_OPCHK;
                        end
                    end
                    mhpq_pkg::OP_CLEAR: begin
                        count_next = '0;
                    end
                    mhpq_pkg::OP_BUILD: begin
                        if (count_reg > 7'd1) begin
                            bld_next   = {1'b0, count_reg[6:1]};
                            state_next = mhpq_pkg::S_BUILD_NEXT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mhpq_pkg::S_OPRD: begin
                // root data is ready
                res_next = rd_data;
                if (op_reg == mhpq_pkg::OP_PEEK) begin
                    state_next = mhpq_pkg::S_RESULT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = adr(count_reg);
                    state_next = mhpq_pkg::S_DEL_RDLAST;
                end
            end
            mhpq_pkg::S_DEL_RDLAST: begin
                // move last to root, shrink, sift down from the root
                count_next = count_reg - 7'd1;
                cur_next   = rd_data;
                pos_next   = 7'd1;
                wr_en      = 1'b1;
                wr_addr    = adr(7'd1);
                wr_data    = rd_data;
                state_next = mhpq_pkg::S_DN_RDL;
            end
            mhpq_pkg::S_OPCHK: begin
                if (op_reg == mhpq_pkg::OP_INCREASE
                    ? mhpq_pkg::key_less(key_reg, rd_data)
                    : mhpq_pkg::key_less(rd_data, key_reg)) begin
                    st_next    = mhpq_pkg::ST_DIR;
                    state_next = mhpq_pkg::S_RESULT;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = adr(pos_reg);
                    wr_data  = key_reg;
                    cur_next = key_reg;
                    state_next = (op_reg == mhpq_pkg::OP_INCREASE) ?
                                 mhpq_pkg::S_UP_RD : mhpq_pkg::S_DN_RDL;
                end
            end
            mhpq_pkg::S_UP_RD: begin
                if (pos_reg <= 7'd1) begin
                    // reached the root: settle the key there
                    wr_en      = 1'b1;
                    wr_addr    = adr(pos_reg);
                    wr_data    = cur_reg;
                    state_next = mhpq_pkg::S_RESULT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = adr({1'b0, pos_reg[6:1]});
                    state_next = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                // parent smaller: parent moves down, key moves up
                if (mhpq_pkg::key_less(rd_data, cur_reg)) begin
                    wr_en      = 1'b1;
                    wr_addr    = adr(pos_reg);
                    wr_data    = rd_data;
                    pos_next   = {1'b0, pos_reg[6:1]};
                    state_next = mhpq_pkg::S_UP_RD;
                end else begin
                    // settle the key at its final place
                    wr_en      = 1'b1;
                    wr_addr    = adr(pos_reg);
                    wr_data    = cur_reg;
                    state_next = mhpq_pkg::S_RESULT;
                end
            end
            mhpq_pkg::S_DN_RDL: begin
                // the moving key is already written at pos_reg
                big_next  = pos_reg;
                lkey_next = cur_reg;
                if (lpos <= count_reg && pos_reg < 7'd64) begin
                    rd_en      = 1'b1;
                    rd_addr    = adr(lpos);
                    state_next = mhpq_pkg::S_DN_RDR;
                end else begin
                    state_next = mhpq_pkg::S_DN_WR;
                end
            end
            mhpq_pkg::S_DN_RDR: begin
                if (mhpq_pkg::key_less(cur_reg, rd_data)) begin
                    big_next  = lpos;
                    lkey_next = rd_data;
                end
                if (rpos <= count_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = adr(rpos);
                    state_next = mhpq_pkg::S_DN_CMP;
                end else begin
                    state_next = mhpq_pkg::S_DN_WR;
                end
            end
            mhpq_pkg::S_DN_CMP: begin
                if (mhpq_pkg::key_less(lkey_reg, rd_data)) begin
                    big_next  = rpos;
                    lkey_next = rd_data;
                end
                state_next = mhpq_pkg::S_DN_WR;
            end
            mhpq_pkg::S_DN_WR: begin
                if (big_reg == pos_reg) begin
                    // sift done: continue the caller
                    if (sorting_reg) begin
                        if (count_reg == 7'd0) begin
                            count_next = total_reg;
                            emit_next  = 7'd1;
                            state_next = mhpq_pkg::S_EMIT_RD;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = adr(7'd1);
                            state_next = mhpq_pkg::S_SORT_RDROOT;
                        end
                    end else if (op_reg == mhpq_pkg::OP_BUILD
                                 || op_reg == mhpq_pkg::OP_SORT) begin
                        state_next = mhpq_pkg::S_BUILD_NEXT;
                    end else begin
                        state_next = mhpq_pkg::S_RESULT;
                    end
                end else begin
                    // child moves up, key moves down
                    wr_en      = 1'b1;
                    wr_addr    = adr(pos_reg);
                    wr_data    = lkey_reg;
                    pos_next   = big_reg;
                    // write key at child in a following pass
                    state_next = mhpq_pkg::S_DEL_WRROOT;
                end
            end
            mhpq_pkg::S_DEL_WRROOT: begin
                wr_en      = 1'b1;
                wr_addr    = adr(pos_reg);
                wr_data    = cur_reg;
                state_next = mhpq_pkg::S_DN_RDL;
            end
            mhpq_pkg::S_SORT_RDROOT: begin
                lkey_next  = rd_data;  // root
                rd_en      = 1'b1;
                rd_addr    = adr(count_reg);
                state_next = mhpq_pkg::S_SORT_RDLAST;
            end
            mhpq_pkg::S_SORT_RDLAST: begin
                // swap root and last, shrink, sift down
                wr_en      = 1'b1;
                wr_addr    = adr(count_reg);
                wr_data    = lkey_reg;
                cur_next   = rd_data;
                state_next = mhpq_pkg::S_SORT_SWAP;
            end
            mhpq_pkg::S_SORT_SWAP: begin
                wr_en      = 1'b1;
                wr_addr    = adr(7'd1);
                wr_data    = cur_reg;
                count_next = count_reg - 7'd1;
                pos_next   = 7'd1;
                state_next = mhpq_pkg::S_DN_RDL;
            end
            mhpq_pkg::S_EMIT_RD: begin
                if (!mv_reg || m_ready) begin
                    rd_en      = 1'b1;
                    rd_addr    = adr(emit_reg);
                    state_next = mhpq_pkg::S_EMIT_OUT;
                end
            end
            mhpq_pkg::S_EMIT_OUT: begin
                st_next   = mhpq_pkg::ST_OK;
                res_next  = rd_data;
                last_next = (emit_reg == total_reg);
                mv_next   = 1'b1;
                if (emit_reg == total_reg) begin
                    sorting_next = 1'b0;
                    bld_next     = {1'b0, count_reg[6:1]};
                    state_next   = mhpq_pkg::S_BUILD_NEXT;
                end else begin
                    emit_next  = emit_reg + 7'd1;
                    state_next = mhpq_pkg::S_EMIT_RD;
                end
            end
            mhpq_pkg::S_EMIT_WAIT: begin
                state_next = mhpq_pkg::S_IDLE;
            end
            mhpq_pkg::S_BUILD_NEXT: begin
                // sift down each internal node, last one first
                if (bld_reg == 7'd0) begin
                    state_next = (op_reg == mhpq_pkg::OP_SORT) ?
                                 mhpq_pkg::S_EMIT_WAIT : mhpq_pkg::S_RESULT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = adr(bld_reg);
                    pos_next   = bld_reg;
                    bld_next   = bld_reg - 7'd1;
                    state_next = mhpq_pkg::S_BUILD_LOAD;
                end
            end
            mhpq_pkg::S_BUILD_LOAD: begin
                // node key has landed: it becomes the moving key
                cur_next   = rd_data;
                state_next = mhpq_pkg::S_DN_RDL;
            end
            mhpq_pkg::S_RESULT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    last_next  = 1'b1;
                    if (st_reg != mhpq_pkg::ST_OK) begin
                        res_next = '0;
                    end
                    state_next = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // result register outputs
    always_comb begin
        s_ready       = (state_reg == mhpq_pkg::S_IDLE) && !mv_reg;
        m_valid       = mv_reg;
        m_status      = st_reg;
        m_result_key  = res_reg;
        m_entry_total = count_reg;
        m_last_result = last_reg;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP7)
        else $error("entry count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second item while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mhpq_pkg::S_DN_WR) |-> (pos_reg != 7'd0))
        else $error("sift at position zero");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CAP = 64;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_opcode;
    logic signed [31:0] s_key_value;
    logic [6:0]         s_position;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_result_key;
    logic [6:0]         m_entry_total;
    logic               m_last_result;

    max_heap_priority_queue_top #(.CAPACITY(CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_key_value(s_key_value), .s_position(s_position),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_result_key(m_result_key),
        .m_entry_total(m_entry_total), .m_last_result(m_last_result)
    );

    // One expected result beat.
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] key;
        logic [6:0]         total;
        logic               last;
    } heap_beat_t;

    // Shadow heap: positions 1..shadow_count in use.
    logic signed [31:0] shadow_heap [1:CAP];
    int                 shadow_count;
    heap_beat_t         pending_beats [$];
    int                 error_count;
    // When set, idle both sides at about 19 percent; otherwise run flat out.
    bit                 idle_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous fixed limit: worst case is well under this.
    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Shadow heap helpers
    // ---------------------------------------------------------------------
    task automatic swap_keys(input int a, input int b);
        logic signed [31:0] t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endtask

    task automatic float_up(input int p);
        while (p > 1 && shadow_heap[p / 2] < shadow_heap[p]) begin
            swap_keys(p, p / 2);
            p = p / 2;
        end
    endtask

    task automatic sink_down(input int p);
        int l, r, big;
        forever begin
            l = 2 * p;
            r = 2 * p + 1;
            big = p;
            if (l <= shadow_count && shadow_heap[big] < shadow_heap[l]) big = l;
            if (r <= shadow_count && shadow_heap[big] < shadow_heap[r]) big = r;
            if (big == p) break;
            swap_keys(p, big);
            p = big;
        end
    endtask

    task automatic heapify_all();
        for (int p = shadow_count / 2; p >= 1; p--) sink_down(p);
    endtask

    // Apply one operation to the shadow heap and queue the beats it yields.
    task automatic predict_heap_op(input logic [3:0] op, input logic signed [31:0] key,
                                   input logic [6:0] pos);
        mhpq_pkg::status_t  st;
        logic signed [31:0] res;
        int                 n;
        st = mhpq_pkg::ST_OK;
        res = '0;
        case (op)
            mhpq_pkg::OP_INSERT, mhpq_pkg::OP_APPEND: begin
                if (shadow_count >= CAP) st = mhpq_pkg::ST_FULL;
                else begin
                    shadow_count++;
                    shadow_heap[shadow_count] = key;
                    if (op == mhpq_pkg::OP_INSERT) float_up(shadow_count);
                end
            end
            mhpq_pkg::OP_PEEK: begin
                if (shadow_count == 0) st = mhpq_pkg::ST_EMPTY;
                else res = shadow_heap[1];
            end
            mhpq_pkg::OP_DELETE: begin
                if (shadow_count == 0) st = mhpq_pkg::ST_EMPTY;
                else begin
                    res = shadow_heap[1];
                    swap_keys(1, shadow_count);
                    shadow_count--;
                    sink_down(1);
                end
            end
            mhpq_pkg::OP_INCREASE, mhpq_pkg::OP_DECREASE: begin
                if (pos == 0 || pos > shadow_count) st = mhpq_pkg::ST_BADPOS;
                else if (op == mhpq_pkg::OP_INCREASE ? key < shadow_heap[pos]
                                                     : shadow_heap[pos] < key)
                    st = mhpq_pkg::ST_DIR;
                else begin
                    shadow_heap[pos] = key;
                    if (op == mhpq_pkg::OP_INCREASE) float_up(pos);
                    else sink_down(pos);
                end
            end
            mhpq_pkg::OP_SORT: begin
                if (shadow_count == 0) st = mhpq_pkg::ST_EMPTY;
                else begin
                    n = shadow_count;
                    while (shadow_count > 0) begin
                        swap_keys(1, shadow_count);
                        shadow_count--;
                        sink_down(1);
                    end
                    shadow_count = n;
                    for (int i = 1; i <= n; i++)
                        pending_beats.push_back({mhpq_pkg::ST_OK, shadow_heap[i], 7'(n),
                                                 i == n});
                    heapify_all();
                    return;
                end
            end
            mhpq_pkg::OP_CLEAR: shadow_count = 0;
            mhpq_pkg::OP_BUILD: heapify_all();
            default: ;
        endcase
        pending_beats.push_back({st, res, 7'(shadow_count), 1'b1});
    endtask

    // ---------------------------------------------------------------------
    // Sender: hold valid and payload until the beat is accepted; valid stays
    // up after the beat until the next idle or the next drain.
    // ---------------------------------------------------------------------
    task automatic send_op(input logic [3:0] op, input logic signed [31:0] key,
                           input logic [6:0] pos);
        if (idle_on && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (idle_on && $urandom_range(99) < 19);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_key_value <= key;
        s_position  <= pos;
        predict_heap_op(op, key, pos);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and pause until every expected beat has been checked.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
    endtask

    // Random key: small half the time so duplicates and equal-key changes occur.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($urandom_range(40)) - 20;
        endcase
    endfunction

    // Position: mostly valid, sometimes zero or past the count, full range too.
    function automatic logic [6:0] pick_pos();
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'($urandom_range(127));
            2:       return 7'(shadow_count + 1);
            default: return shadow_count == 0 ? 7'd1 : 7'($urandom_range(shadow_count, 1));
        endcase
    endfunction

    // Receiver: random stalls, compare each beat with the oldest expectation.
    always @(posedge aclk) begin
        heap_beat_t exp_beat;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_beats.size() == 0) begin
                    $display("%0t: unexpected beat status=%0d key=%0d total=%0d last=%0d",
                             $time, m_status, m_result_key, m_entry_total, m_last_result);
                    error_count++;
                end else begin
                    exp_beat = pending_beats.pop_front();
                    if (m_status !== exp_beat.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_beat.status, m_status);
                        error_count++;
                    end
                    if (m_result_key !== exp_beat.key) begin
                        $display("%0t: result_key expected %0d actual %0d",
                                 $time, exp_beat.key, m_result_key);
                        error_count++;
                    end
                    if (m_entry_total !== exp_beat.total) begin
                        $display("%0t: entry_total expected %0d actual %0d",
                                 $time, exp_beat.total, m_entry_total);
                        error_count++;
                    end
                    if (m_last_result !== exp_beat.last) begin
                        $display("%0t: last_result expected %0d actual %0d",
                                 $time, exp_beat.last, m_last_result);
                        error_count++;
                    end
                end
            end
            m_ready <= idle_on ? ($urandom_range(99) >= 19) : 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_empty_heap();
        send_op(mhpq_pkg::OP_PEEK, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_DELETE, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_SORT, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_BUILD, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_INCREASE, 32'sd5, 7'd1);
        send_op(mhpq_pkg::OP_DECREASE, 32'sd5, 7'd0);
        send_op(4'd15, 32'sh7fffffff, 7'h7f);
        send_op(4'd9, 32'sd0, 7'd0);
    endtask

    task automatic test_basic_ops();
        send_op(mhpq_pkg::OP_INSERT, 32'sh80000000, 7'd0);
        send_op(mhpq_pkg::OP_INSERT, 32'sh7fffffff, 7'd0);
        send_op(mhpq_pkg::OP_INSERT, -32'sd1, 7'd0);
        send_op(mhpq_pkg::OP_INSERT, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_PEEK, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_INCREASE, 32'sh7fffffff, 7'd4);   // accepted; key rises past its parent
        send_op(mhpq_pkg::OP_INCREASE, 32'sh80000000, 7'd2);   // wrong direction
        send_op(mhpq_pkg::OP_DECREASE, 32'sh7fffffff, 7'd3);   // wrong direction
        send_op(mhpq_pkg::OP_DECREASE, 32'sh80000000, 7'd1);
        send_op(mhpq_pkg::OP_DECREASE, 32'sd0, 7'd5);          // past the count
        send_op(mhpq_pkg::OP_DELETE, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_SORT, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_APPEND, 32'sd3, 7'd0);
        send_op(mhpq_pkg::OP_APPEND, 32'sd9, 7'd0);
        send_op(mhpq_pkg::OP_BUILD, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_CLEAR, 32'sd0, 7'd0);
        drain_results();
    endtask

    // Fill to capacity, overflow both ways, then sort the full heap.
    task automatic test_full_heap();
        for (int i = 0; i < CAP; i++) send_op(mhpq_pkg::OP_APPEND, pick_key(), 7'd0);
        send_op(mhpq_pkg::OP_INSERT, 32'sd1, 7'd0);
        send_op(mhpq_pkg::OP_APPEND, 32'sd1, 7'd0);
        send_op(mhpq_pkg::OP_BUILD, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_SORT, 32'sd0, 7'd0);
        send_op(mhpq_pkg::OP_INCREASE, 32'sh7fffffff, 7'd64);
        send_op(mhpq_pkg::OP_CLEAR, 32'sd0, 7'd0);
    endtask

    // Well-formed mixes on small heaps, with a few sorts and some noise.
    task automatic test_random_mix(input int count);
        int               r;
        logic [3:0]       op;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if      (r < 30) op = mhpq_pkg::OP_INSERT;
            else if (r < 40) op = mhpq_pkg::OP_PEEK;
            else if (r < 58) op = mhpq_pkg::OP_DELETE;
            else if (r < 68) op = mhpq_pkg::OP_INCREASE;
            else if (r < 78) op = mhpq_pkg::OP_DECREASE;
            else if (r < 83) op = mhpq_pkg::OP_APPEND;
            else if (r < 87) op = mhpq_pkg::OP_BUILD;
            else if (r < 90) op = (shadow_count <= 16) ? mhpq_pkg::OP_SORT : mhpq_pkg::OP_PEEK;
            else if (r < 92) op = mhpq_pkg::OP_CLEAR;
            else if (r < 94) op = 4'($urandom_range(15, 9));
            else             op = mhpq_pkg::OP_INSERT;
            send_op(op, pick_key(), pick_pos());
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = '0;
        s_key_value = '0;
        s_position  = '0;
        error_count = 0;
        shadow_count = 0;
        idle_on     = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_heap();
        test_basic_ops();
        test_full_heap();
        test_random_mix(200);
        drain_results();
        // long stretch with no idling on either side
        idle_on = 1'b0;
        test_random_mix(120);
        idle_on = 1'b1;
        test_random_mix(60);

        drain_results();
        repeat (200) @(posedge aclk);
        if (error_count == 0 && pending_beats.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
